FILE: rtl/zcsf_pkg.sv
`timescale 1ns / 1ps
package zcsf_pkg;

  // block geometry
  localparam int MAX_CROSSINGS = 64;
  localparam int IDX_W         = 16;
  localparam int SAMPLE_W      = 16;
  localparam int CNT_W         = IDX_W + 1;
  localparam int PTR_W         = $clog2(MAX_CROSSINGS);
  localparam int KCNT_W        = PTR_W + 1;

  // spacing test: d * count * 2^FRAC_W > margin * samples
  localparam int MARGIN_W      = 16;
  localparam int FRAC_W        = 8;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(256);
  localparam int PROD_W        = IDX_W + CNT_W;
  localparam int RHS_W         = MARGIN_W + CNT_W;
  localparam int CMP_W         = (PROD_W + FRAC_W > RHS_W) ? PROD_W + FRAC_W : RHS_W;

  // front-to-back queue
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);

  // one queue entry: a stored crossing, the end of a block, or both
  typedef struct packed {
    logic               has_idx;
    logic               is_end;
    logic               ovf;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cross_cnt;
    logic [CNT_W-1:0]   samp_cnt;
  } q_entry_t;

endpackage

FILE: rtl/zcsf_ram.sv
`timescale 1ns / 1ps
module zcsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/zcsf_front.sv
`timescale 1ns / 1ps
module zcsf_front
  import zcsf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_sample,
  output logic                       q_push,
  output q_entry_t                   q_data,
  input  logic                       q_full
);

  logic [CNT_W-1:0] samp_cnt_r, samp_cnt_nxt;
  logic [CNT_W-1:0] cross_cnt_r, cross_cnt_nxt;
  logic             was_nonneg_r;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic             nonneg;
  logic             crossing;
  logic             too_wide;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the sample against the previous sign
  assign nonneg   = !in_sample[SAMPLE_W-1];
  assign crossing = (samp_cnt_r == '0) ? (in_sample == '0) : (nonneg != was_nonneg_r);
  assign too_wide = samp_cnt_r[CNT_W-1];

  // saturating counts and overflow for this beat
  always_comb begin
    cross_cnt_nxt = cross_cnt_r;
    ovf_nxt       = ovf_r;
    if (crossing) begin
      if (cross_cnt_r != '1) begin
        cross_cnt_nxt = cross_cnt_r + CNT_W'(1);
      end
      if (too_wide) begin
        ovf_nxt = 1'b1;
      end
    end
    samp_cnt_nxt = (samp_cnt_r != '1) ? samp_cnt_r + CNT_W'(1) : samp_cnt_r;
  end

  // queue entry: crossing index and, on the last sample, block totals
  always_comb begin
    q_data.has_idx   = crossing && !too_wide;
    q_data.is_end    = in_last_sample;
    q_data.ovf       = ovf_nxt;
    q_data.idx       = samp_cnt_r[IDX_W-1:0];
    q_data.cross_cnt = cross_cnt_nxt;
    q_data.samp_cnt  = samp_cnt_nxt;
  end

  assign q_push = accept && ((crossing && !too_wide) || in_last_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_cnt_r   <= '0;
      cross_cnt_r  <= '0;
      was_nonneg_r <= 1'b0;
      ovf_r        <= 1'b0;
    end else if (accept) begin
      if (in_last_sample) begin
        samp_cnt_r   <= '0;
        cross_cnt_r  <= '0;
        was_nonneg_r <= 1'b0;
        ovf_r        <= 1'b0;
      end else begin
        samp_cnt_r   <= samp_cnt_nxt;
        cross_cnt_r  <= cross_cnt_nxt;
        was_nonneg_r <= nonneg;
        ovf_r        <= ovf_nxt;
      end
    end
  end

endmodule

FILE: rtl/zcsf_queue.sv
`timescale 1ns / 1ps
module zcsf_queue
  import zcsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     empty
);

  q_entry_t             entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (Q_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (Q_PTR_W + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/zcsf_back.sv
`timescale 1ns / 1ps
module zcsf_back
  import zcsf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [MARGIN_W-1:0] margin_q8,
  input  q_entry_t            q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_crossing_index,
  output logic                out_end_of_list,
  output logic                out_list_empty,
  output logic                out_overflow
);

  typedef enum logic [3:0] {
    S_FILL, S_INIT_RD, S_INIT_LD, S_RD, S_SUB, S_MUL, S_CMP, S_E_RD, S_E_LD, S_E_OUT
  } state_t;

  state_t              state_r;
  logic [KCNT_W-1:0]   stored_n_r;
  logic [KCNT_W-1:0]   k_r;
  logic [KCNT_W-1:0]   kept_n_r;
  logic [KCNT_W-1:0]   e_idx_r;
  logic [IDX_W-1:0]    anchor_r;
  logic [IDX_W-1:0]    prev_r;
  logic [IDX_W-1:0]    val_r;
  logic [IDX_W-1:0]    d_r;
  logic [PROD_W-1:0]   prod_r;
  logic [RHS_W-1:0]    rhs_r;
  logic [CNT_W-1:0]    cc_r;
  logic                skip_r;
  logic                ovf_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_eol_r;
  logic                out_empty_r;
  logic                out_ovf_r;

  logic                store_full;
  logic                far;
  logic                cr_we;
  logic [IDX_W-1:0]    cr_rdata;
  logic                kp_we;
  logic [IDX_W-1:0]    kp_wdata;
  logic [IDX_W-1:0]    kp_rdata;

  // drain the queue only while loading a block
  assign q_pop      = (state_r == S_FILL) && !q_empty;
  assign store_full = (stored_n_r == KCNT_W'(MAX_CROSSINGS));
  assign cr_we      = q_pop && q_data.has_idx && !store_full;

  // spacing test against the precomputed right-hand side
  assign far = (CMP_W'(prod_r) << FRAC_W) > CMP_W'(rhs_r);

  // kept list is a stack: push on the first crossing and on each far one
  assign kp_we    = (state_r == S_INIT_LD) || ((state_r == S_CMP) && far);
  assign kp_wdata = (state_r == S_INIT_LD) ? cr_rdata : val_r;

  zcsf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CROSSINGS)) u_cross_ram (
    .clk   (clk),
    .we    (cr_we),
    .waddr (stored_n_r[PTR_W-1:0]),
    .wdata (q_data.idx),
    .raddr (k_r[PTR_W-1:0]),
    .rdata (cr_rdata)
  );

  zcsf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CROSSINGS)) u_kept_ram (
    .clk   (clk),
    .we    (kp_we),
    .waddr (kept_n_r[PTR_W-1:0]),
    .wdata (kp_wdata),
    .raddr (e_idx_r[PTR_W-1:0]),
    .rdata (kp_rdata)
  );

  // sequencer: load, walk, emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      stored_n_r  <= '0;
      k_r         <= '0;
      kept_n_r    <= '0;
      e_idx_r     <= '0;
      skip_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_FILL: begin
          if (q_pop) begin
            if (q_data.has_idx && !store_full) begin
              stored_n_r <= stored_n_r + KCNT_W'(1);
            end
            if ((q_data.has_idx && store_full) || (q_data.is_end && q_data.ovf)) begin
              ovf_r <= 1'b1;
            end
            if (q_data.is_end) begin
              cc_r    <= q_data.cross_cnt;
              rhs_r   <= RHS_W'(margin_q8) * RHS_W'(q_data.samp_cnt);
              k_r     <= '0;
              state_r <= S_INIT_RD;
            end
          end
        end
        S_INIT_RD: begin
          kept_n_r <= '0;
          e_idx_r  <= '0;
          state_r  <= (stored_n_r == '0) ? S_E_RD : S_INIT_LD;
        end
        S_INIT_LD: begin
          anchor_r <= cr_rdata;
          prev_r   <= cr_rdata;
          kept_n_r <= KCNT_W'(1);
          skip_r   <= 1'b0;
          k_r      <= KCNT_W'(1);
          state_r  <= (stored_n_r == KCNT_W'(1)) ? S_E_RD : S_RD;
        end
        S_RD: begin
          state_r <= S_SUB;
        end
        S_SUB: begin
          val_r   <= cr_rdata;
          d_r     <= cr_rdata - anchor_r;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PROD_W'(d_r) * PROD_W'(cc_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (far) begin
            kept_n_r <= kept_n_r + KCNT_W'(1);
            prev_r   <= anchor_r;
            anchor_r <= val_r;
            skip_r   <= 1'b0;
          end else if (!skip_r) begin
            // near crossing: drop the last kept entry, fall back one anchor
            if (kept_n_r != '0) begin
              kept_n_r <= kept_n_r - KCNT_W'(1);
            end
            anchor_r <= prev_r;
            skip_r   <= 1'b1;
          end
          k_r     <= k_r + KCNT_W'(1);
          state_r <= (k_r + KCNT_W'(1) == stored_n_r) ? S_E_RD : S_RD;
        end
        S_E_RD: begin
          state_r <= S_E_LD;
        end
        S_E_LD: begin
          out_valid_r <= 1'b1;
          out_ovf_r   <= ovf_r;
          if (kept_n_r == '0) begin
            out_idx_r   <= '0;
            out_eol_r   <= 1'b1;
            out_empty_r <= 1'b1;
          end else begin
            out_idx_r   <= kp_rdata;
            out_eol_r   <= (e_idx_r + KCNT_W'(1) == kept_n_r);
            out_empty_r <= 1'b0;
          end
          state_r <= S_E_OUT;
        end
        S_E_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_eol_r) begin
              stored_n_r <= '0;
              ovf_r      <= 1'b0;
              state_r    <= S_FILL;
            end else begin
              e_idx_r <= e_idx_r + KCNT_W'(1);
              state_r <= S_E_RD;
            end
          end
        end
        default: begin
          state_r <= S_FILL;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_crossing_index = out_idx_r;
  assign out_end_of_list    = out_eol_r;
  assign out_list_empty     = out_empty_r;
  assign out_overflow       = out_ovf_r;

endmodule

FILE: rtl/zero_crossing_spacing_filter_unit.sv
`timescale 1ns / 1ps
// Zero-crossing spacing filter. Samples stream in one per cycle; the front
// records each sign change (and index 0 when the first sample is exactly
// zero) into a 4-entry queue, and keeps taking samples, also those of the
// next block, as long as that queue has room. The back moves crossings into
// a 64-entry store at one per cycle while it is loading a block. After the
// last sample of a block it walks the store: a read of the first crossing,
// then for each further one a store read, subtract, multiply and compare.
// It then emits the kept indices, each beat as a store read, a load and an
// output held until out_ready; a block with no surviving crossing gives one
// beat with list_empty set. margin_q8 must be written through the cfg port
// only while the block is idle; the block itself does not enforce this.
module zero_crossing_spacing_filter_unit
  import zcsf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [MARGIN_W-1:0]        cfg_margin_q8,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [IDX_W-1:0]           out_crossing_index,
  output logic                       out_end_of_list,
  output logic                       out_list_empty,
  output logic                       out_overflow
);

  logic [MARGIN_W-1:0] margin_r;
  logic                q_push;
  q_entry_t            q_push_data;
  logic                q_full;
  logic                q_pop;
  q_entry_t            q_pop_data;
  logic                q_empty;

  // margin register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      margin_r <= cfg_margin_q8;
    end
  end

  zcsf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .q_push         (q_push),
    .q_data         (q_push_data),
    .q_full         (q_full)
  );

  zcsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  zcsf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .margin_q8          (margin_r),
    .q_data             (q_pop_data),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_crossing_index (out_crossing_index),
    .out_end_of_list    (out_end_of_list),
    .out_list_empty     (out_list_empty),
    .out_overflow       (out_overflow)
  );

endmodule
